FILE: design/assert_macros.svh
// Assertion macros shared by the pixel format converter RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/pfcc_pkg.sv
// Package for the pixel format converter: format codes, stage payload types,
// fixed-point coefficients. No dependencies.
`timescale 1ns / 1ps

package pfcc_pkg;

  // Fixed-point fraction bits of the conversion coefficients.
  localparam int COEF_FRAC_BITS = 14;
  localparam int KW             = COEF_FRAC_BITS + 2;  // signed coefficient width
  localparam int XW             = 9;                    // signed operand width
  localparam int PROD_W         = KW + XW;
  localparam int SUM_W          = PROD_W + 2;

  // Packing codes.
  localparam logic [2:0] FMT_RGB24 = 3'd0;
  localparam logic [2:0] FMT_ARGB  = 3'd1;
  localparam logic [2:0] FMT_BGRA  = 3'd2;
  localparam logic [2:0] FMT_AYUV  = 3'd3;
  localparam logic [2:0] FMT_VUYA  = 3'd4;

  // Configuration register indexes.
  localparam logic REG_INPUT_FORMAT  = 1'b0;
  localparam logic REG_OUTPUT_FORMAT = 1'b1;

  typedef logic signed [KW-1:0]     coef_t;
  typedef logic signed [XW-1:0]     opnd_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Thousandths to fixed point, rounded to nearest.
  localparam int K_299  = ((299  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_587  = ((587  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_114  = ((114  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_169  = ((169  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_331  = ((331  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_500  = ((500  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_419  = ((419  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_081  = ((81   << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_1403 = ((1403 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_344  = ((344  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_714  = ((714  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_1773 = ((1773 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_ONE  = 1 << COEF_FRAC_BITS;
  localparam int HALF   = 128 << COEF_FRAC_BITS;

  // What the matrix stage does with a pixel.
  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,   // equal or undefined formats: all-zero result
    MODE_PASS = 2'd1,   // same family: reorder only
    MODE_R2Y  = 2'd2,   // RGB family to YUV family
    MODE_Y2R  = 2'd3    // YUV family to RGB family
  } mode_t;

  // Fields that ride alongside the color math.
  typedef struct packed {
    logic [7:0] alpha;
    mode_t      mode;
    logic [2:0] fo;
    logic       last;
  } side_t;

  // Unpack stage result: three signed operands.
  typedef struct packed {
    opnd_t x0;
    opnd_t x1;
    opnd_t x2;
    side_t side;
  } unp_t;

  // Matrix stage result: three saturated components.
  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    side_t      side;
  } mat_t;

  // Packed output pixel.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] cnt;
    logic       last;
  } pix_t;

endpackage

FILE: design/pfcc_unpack.sv
// Stage 1: decode formats, unpack bytes into components and operands.
// Depends on pfcc_pkg.
`timescale 1ns / 1ps

module pfcc_unpack (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      fi,
  input  logic [2:0]      fo,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     in_bytes,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_ready,
  output pfcc_pkg::unp_t  out_data
);

  logic           valid_r;
  pfcc_pkg::unp_t data_r;
  pfcc_pkg::unp_t data_nxt;

  logic [7:0] b0, b1, b2, b3;
  logic [7:0] c0, c1, c2, a;
  logic       ok, yi, yo;

  assign b0 = in_bytes[7:0];
  assign b1 = in_bytes[15:8];
  assign b2 = in_bytes[23:16];
  assign b3 = in_bytes[31:24];

  always_comb begin
    ok = (fi <= pfcc_pkg::FMT_VUYA) && (fo <= pfcc_pkg::FMT_VUYA) && (fi != fo);
    yi = fi inside {pfcc_pkg::FMT_AYUV, pfcc_pkg::FMT_VUYA};
    yo = fo inside {pfcc_pkg::FMT_AYUV, pfcc_pkg::FMT_VUYA};

    case (fi)
      pfcc_pkg::FMT_RGB24: begin
        c0 = b0; c1 = b1; c2 = b2; a = 8'hFF;
      end
      pfcc_pkg::FMT_ARGB, pfcc_pkg::FMT_AYUV: begin
        a = b0; c0 = b1; c1 = b2; c2 = b3;
      end
      default: begin
        c2 = b0; c1 = b1; c0 = b2; a = b3;
      end
    endcase

    data_nxt.side.alpha = a;
    data_nxt.side.fo    = fo;
    data_nxt.side.last  = in_last;
    if (!ok)
      data_nxt.side.mode = pfcc_pkg::MODE_ZERO;
    else if (yi == yo)
      data_nxt.side.mode = pfcc_pkg::MODE_PASS;
    else if (yo)
      data_nxt.side.mode = pfcc_pkg::MODE_R2Y;
    else
      data_nxt.side.mode = pfcc_pkg::MODE_Y2R;

    // chroma is centered on 128 for YUV to RGB
    data_nxt.x0 = $signed({1'b0, c0});
    if (data_nxt.side.mode == pfcc_pkg::MODE_Y2R) begin
      data_nxt.x1 = $signed({1'b0, c1}) - 9'sd128;
      data_nxt.x2 = $signed({1'b0, c2}) - 9'sd128;
    end else begin
      data_nxt.x1 = $signed({1'b0, c1});
      data_nxt.x2 = $signed({1'b0, c2});
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: design/pfcc_matrix.sv
// Stages 2 and 3: 3x3 coefficient multiply, then sum, floor and saturate.
// Depends on pfcc_pkg.
`timescale 1ns / 1ps

module pfcc_matrix (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pfcc_pkg::unp_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output pfcc_pkg::mat_t  out_data
);

  // stage 2: products
  logic             s2_valid_r;
  logic             s2_ready;
  pfcc_pkg::side_t  s2_side_r;
  pfcc_pkg::prod_t  prod_r   [3][3];
  pfcc_pkg::prod_t  prod_nxt [3][3];
  pfcc_pkg::coef_t  k        [3][3];
  pfcc_pkg::opnd_t  x        [3];

  // stage 3: sums
  logic             s3_valid_r;
  logic             s3_ready;
  pfcc_pkg::mat_t   s3_r;
  pfcc_pkg::mat_t   s3_nxt;
  pfcc_pkg::sum_t   off      [3];
  pfcc_pkg::sum_t   sum      [3];
  pfcc_pkg::sum_t   flr      [3];
  logic [7:0]       sat      [3];

  always_comb begin
    x[0] = in_data.x0;
    x[1] = in_data.x1;
    x[2] = in_data.x2;

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        k[i][j] = '0;
      end
    end

    case (in_data.side.mode)
      pfcc_pkg::MODE_R2Y: begin
        k[0][0] = pfcc_pkg::coef_t'(pfcc_pkg::K_299);
        k[0][1] = pfcc_pkg::coef_t'(pfcc_pkg::K_587);
        k[0][2] = pfcc_pkg::coef_t'(pfcc_pkg::K_114);
        k[1][0] = pfcc_pkg::coef_t'(-pfcc_pkg::K_169);
        k[1][1] = pfcc_pkg::coef_t'(-pfcc_pkg::K_331);
        k[1][2] = pfcc_pkg::coef_t'(pfcc_pkg::K_500);
        k[2][0] = pfcc_pkg::coef_t'(pfcc_pkg::K_500);
        k[2][1] = pfcc_pkg::coef_t'(-pfcc_pkg::K_419);
        k[2][2] = pfcc_pkg::coef_t'(-pfcc_pkg::K_081);
      end
      pfcc_pkg::MODE_Y2R: begin
        k[0][0] = pfcc_pkg::coef_t'(pfcc_pkg::K_ONE);
        k[0][2] = pfcc_pkg::coef_t'(pfcc_pkg::K_1403);
        k[1][0] = pfcc_pkg::coef_t'(pfcc_pkg::K_ONE);
        k[1][1] = pfcc_pkg::coef_t'(-pfcc_pkg::K_344);
        k[1][2] = pfcc_pkg::coef_t'(-pfcc_pkg::K_714);
        k[2][0] = pfcc_pkg::coef_t'(pfcc_pkg::K_ONE);
        k[2][1] = pfcc_pkg::coef_t'(pfcc_pkg::K_1773);
      end
      pfcc_pkg::MODE_PASS: begin
        k[0][0] = pfcc_pkg::coef_t'(pfcc_pkg::K_ONE);
        k[1][1] = pfcc_pkg::coef_t'(pfcc_pkg::K_ONE);
        k[2][2] = pfcc_pkg::coef_t'(pfcc_pkg::K_ONE);
      end
      default: begin
      end
    endcase

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = pfcc_pkg::prod_t'(k[i][j]) * pfcc_pkg::prod_t'(x[j]);
      end
    end
  end

  assign s2_ready = !s2_valid_r || s3_ready;
  assign in_ready = s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s2_ready) begin
      prod_r    <= prod_nxt;
      s2_side_r <= in_data.side;
    end
  end

  // chroma offset of +128 only on the way into YUV
  always_comb begin
    off[0] = '0;
    off[1] = '0;
    off[2] = '0;
    if (s2_side_r.mode == pfcc_pkg::MODE_R2Y) begin
      off[1] = pfcc_pkg::sum_t'(pfcc_pkg::HALF);
      off[2] = pfcc_pkg::sum_t'(pfcc_pkg::HALF);
    end

    for (int i = 0; i < 3; i++) begin
      sum[i] = pfcc_pkg::sum_t'(prod_r[i][0]) + pfcc_pkg::sum_t'(prod_r[i][1])
             + pfcc_pkg::sum_t'(prod_r[i][2]) + off[i];
      flr[i] = sum[i] >>> pfcc_pkg::COEF_FRAC_BITS;   // arithmetic shift floors
      if (flr[i] < 0)
        sat[i] = 8'd0;
      else if (flr[i] > pfcc_pkg::sum_t'(255))
        sat[i] = 8'd255;
      else
        sat[i] = flr[i][7:0];
    end

    s3_nxt.c0   = sat[0];
    s3_nxt.c1   = sat[1];
    s3_nxt.c2   = sat[2];
    s3_nxt.side = s2_side_r;
  end

  assign s3_ready  = !s3_valid_r || out_ready;
  assign out_valid = s3_valid_r;
  assign out_data  = s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && s3_ready) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

FILE: design/pfcc_pack.sv
// Stage 4: reorder components into the output packing; output register.
// Depends on pfcc_pkg.
`timescale 1ns / 1ps

module pfcc_pack (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pfcc_pkg::mat_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output pfcc_pkg::pix_t  out_data
);

  logic           valid_r;
  pfcc_pkg::pix_t data_r;
  pfcc_pkg::pix_t data_nxt;

  always_comb begin
    data_nxt      = '0;
    data_nxt.last = in_data.side.last;
    if (in_data.side.mode != pfcc_pkg::MODE_ZERO) begin
      case (in_data.side.fo)
        pfcc_pkg::FMT_RGB24: begin
          data_nxt.b0  = in_data.c0;
          data_nxt.b1  = in_data.c1;
          data_nxt.b2  = in_data.c2;
          data_nxt.cnt = 3'd3;
        end
        pfcc_pkg::FMT_ARGB, pfcc_pkg::FMT_AYUV: begin
          data_nxt.b0  = in_data.side.alpha;
          data_nxt.b1  = in_data.c0;
          data_nxt.b2  = in_data.c1;
          data_nxt.b3  = in_data.c2;
          data_nxt.cnt = 3'd4;
        end
        default: begin
          data_nxt.b0  = in_data.c2;
          data_nxt.b1  = in_data.c1;
          data_nxt.b2  = in_data.c0;
          data_nxt.b3  = in_data.side.alpha;
          data_nxt.cnt = 3'd4;
        end
      endcase
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: design/pixel_format_color_convert_top.sv
// Pixel format converter top level: config registers and four-stage pipeline.
// Depends on pfcc_pkg, pfcc_unpack, pfcc_matrix, pfcc_pack, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Converts one pixel per transaction between RGB24, ARGB, BGRA, AYUV and VUYA
// packings. Across the RGB/YUV families the color is converted with
// full-range BT.601 equations in signed fixed point (floored, clamped to
// 0..255); within a family bytes are only reordered. Alpha becomes 255 when
// the source has none and is dropped for RGB24. Equal or undefined formats
// give all-zero bytes and a byte count of 0; tlast is always copied.
// Throughput is one pixel per clock while out_tready stays high. There are
// four register stages (unpack, 3x3 multiply, sum/saturate, repack), which a
// pixel passes in that order. Every stage holds its pixel under backpressure,
// so in_tready drops only when all four stages are full and out_tready is low.
// Write the format registers only while the pipeline is empty.
module pixel_format_color_convert_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,      // 0 input_format, 1 output_format
  input  logic [2:0]  cfg_wdata,
  // pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // in_byte0, in_byte1, in_byte2, in_byte3
  input  logic        in_tlast,      // last_pixel_in
  // pixel output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // out_byte0..out_byte3, byte_count, 5'b0 pad
  output logic        out_tlast      // last_pixel_out
);

  logic [2:0] input_format_r;
  logic [2:0] output_format_r;

  logic           unp_valid, unp_ready;
  pfcc_pkg::unp_t unp_data;
  logic           mat_valid, mat_ready;
  pfcc_pkg::mat_t mat_data;
  pfcc_pkg::pix_t pix;

  logic           cnt_legal;
  logic           pipe_full;

  // format registers, plain write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_format_r  <= pfcc_pkg::FMT_RGB24;
      output_format_r <= pfcc_pkg::FMT_ARGB;
    end else if (cfg_we) begin
      case (cfg_addr)
        pfcc_pkg::REG_INPUT_FORMAT:  input_format_r  <= cfg_wdata;
        pfcc_pkg::REG_OUTPUT_FORMAT: output_format_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  pfcc_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .fi        (input_format_r),
    .fo        (output_format_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_bytes  (in_tdata),
    .in_last   (in_tlast),
    .out_valid (unp_valid),
    .out_ready (unp_ready),
    .out_data  (unp_data)
  );

  pfcc_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (unp_valid),
    .in_ready  (unp_ready),
    .in_data   (unp_data),
    .out_valid (mat_valid),
    .out_ready (mat_ready),
    .out_data  (mat_data)
  );

  pfcc_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mat_valid),
    .in_ready  (mat_ready),
    .in_data   (mat_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (pix)
  );

  assign out_tdata = {5'b0, pix.cnt, pix.b3, pix.b2, pix.b1, pix.b0};
  assign out_tlast = pix.last;

  assign cnt_legal = (pix.cnt == 3'd0) || (pix.cnt == 3'd3) || (pix.cnt == 3'd4);
  assign pipe_full = unp_valid && mat_valid && out_tvalid;

  // byte count is one of 0, 3, 4
  `ASSERT_CLK(a_cnt_legal, out_tvalid |-> cnt_legal, "illegal byte count")
  // RGB24 results and empty results carry no fourth byte
  `ASSERT_CLK(a_b3_zero, (out_tvalid && pix.cnt != 3'd4) |-> (pix.b3 == 8'd0), "b3 not zero")
  // input backpressure only when the unpack, sum and repack stages are full and stalled
  `ASSERT_CLK(a_full_stall, !in_tready |-> (pipe_full && !out_tready), "stall with bubble")
  // no output right after reset
  `ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_tvalid, "output valid after reset")

endmodule
